[design/cal_pkg.sv]
`default_nettype none

package cal_pkg;

  // Operation codes carried in tuser.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Field widths.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int CENT_W  = 7;
  localparam int WDAY_W  = 3;
  localparam int SUM_W   = 10;

  // Date limits and reset date.
  localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
  localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR   = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
  localparam logic [YEAR_W-1:0]  YEAR_FIRST  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2000;
  localparam logic [YEAR_W-1:0]  YEAR_CENT   = 14'd100;
  localparam logic [CENT_W-1:0]  CENT_RESET  = 7'd20;
  localparam logic [CENT_W-1:0]  CENT_LAST   = 7'd99;

  // Year / 100 as a multiply by a scaled reciprocal; exact for all 14-bit years.
  localparam int                    DIV100_MUL_W = 13;
  localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int                    DIV100_SHIFT = 19;

  // Input word as it arrives on the slave side.
  typedef struct packed {
    logic               op;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } item_t;

  // Input word after clamping, with the century split off.
  typedef struct packed {
    logic               op;
    logic [CENT_W-1:0]  cent;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } split_t;

  // Stored date; the year is also kept as century and year within century.
  typedef struct packed {
    logic               overflow;
    logic [CENT_W-1:0]  yr_hi;
    logic [CENT_W-1:0]  yr_lo;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Result word, day in the lowest bits.
  typedef struct packed {
    logic               overflow;
    logic               leap;
    logic [WDAY_W-1:0]  weekday;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } res_t;

  // Gregorian leap rule from the split year.
  function automatic logic is_leap(input logic [CENT_W-1:0] yr_lo,
                                   input logic [CENT_W-1:0] yr_hi);
    if (yr_lo == '0) begin
      return (yr_hi[1:0] == 2'b00);
    end
    return (yr_lo[1:0] == 2'b00);
  endfunction

  // Days in a month.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Month term of Zeller's congruence, floor(13 * (m + 1) / 5), with
  // January and February counted as months 13 and 14.
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] month);
    logic [5:0] t;
    case (month)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[design/cal_split.sv]
`default_nettype none

module cal_split (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cal_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cal_pkg::split_t out_item
);
  import cal_pkg::*;

  item_t  clamped;
  item_t  s1_item;
  logic   s1_valid;
  logic   s1_ready;
  logic   s2_ready;
  logic [YEAR_W+DIV100_MUL_W-1:0] prod;

  // Clamp the load fields into the legal date range.
  always_comb begin
    clamped = in_item;
    if (in_item.day == '0) begin
      clamped.day = DAY_FIRST;
    end
    if (in_item.month == '0) begin
      clamped.month = MONTH_JAN;
    end else if (in_item.month > MONTH_DEC) begin
      clamped.month = MONTH_DEC;
    end
    if (in_item.year == '0) begin
      clamped.year = YEAR_FIRST;
    end else if (in_item.year > YEAR_MAX) begin
      clamped.year = YEAR_MAX;
    end
  end

  // Each stage moves when the one after it is empty or moving.
  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_item <= clamped;
    end
  end

  // Century by reciprocal multiply.
  assign prod = (YEAR_W+DIV100_MUL_W)'(s1_item.year) * (YEAR_W+DIV100_MUL_W)'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      out_item.op    <= s1_item.op;
      out_item.day   <= s1_item.day;
      out_item.month <= s1_item.month;
      out_item.year  <= s1_item.year;
      out_item.cent  <= prod[DIV100_SHIFT +: CENT_W];
    end
  end

endmodule

`default_nettype wire

[design/cal_date.sv]
`default_nettype none

module cal_date (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cal_pkg::split_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output cal_pkg::date_t  out_item
);
  import cal_pkg::*;

  date_t             date_next;
  logic [YEAR_W-1:0] hund;
  logic [YEAR_W-1:0] rem;
  logic              leap;
  logic [DAY_W-1:0]  mlen;

  // The date register is the stage payload: it only changes when a word enters.
  assign in_ready = !out_valid || out_ready;

  assign hund = YEAR_W'(in_item.cent) * YEAR_W'(YEAR_CENT);
  assign rem  = in_item.year - hund;
  assign leap = is_leap(out_item.yr_lo, out_item.yr_hi);
  assign mlen = month_length(out_item.month, leap);

  // Next date: load the clamped date, or step one day with month and year carry.
  always_comb begin
    date_next          = out_item;
    date_next.overflow = 1'b0;
    if (in_item.op == OP_LOAD) begin
      date_next.day   = in_item.day;
      date_next.month = in_item.month;
      date_next.year  = in_item.year;
      date_next.yr_hi = in_item.cent;
      date_next.yr_lo = rem[CENT_W-1:0];
    end else if (out_item.day >= mlen) begin
      if (out_item.month >= MONTH_DEC) begin
        if (out_item.year >= YEAR_MAX) begin
          date_next.overflow = 1'b1;
        end else begin
          date_next.day   = DAY_FIRST;
          date_next.month = MONTH_JAN;
          date_next.year  = out_item.year + 1'b1;
          if (out_item.yr_lo == CENT_LAST) begin
            date_next.yr_lo = '0;
            date_next.yr_hi = out_item.yr_hi + 1'b1;
          end else begin
            date_next.yr_lo = out_item.yr_lo + 1'b1;
          end
        end
      end else begin
        date_next.day   = DAY_FIRST;
        date_next.month = out_item.month + 1'b1;
      end
    end else begin
      date_next.day = out_item.day + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      out_item.day      <= DAY_FIRST;
      out_item.month    <= MONTH_JAN;
      out_item.year     <= YEAR_RESET;
      out_item.yr_hi    <= CENT_RESET;
      out_item.yr_lo    <= '0;
      out_item.overflow <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        out_item <= date_next;
      end
    end
  end

endmodule

`default_nettype wire

[design/cal_weekday.sv]
`default_nettype none

module cal_weekday (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cal_pkg::date_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output cal_pkg::res_t  out_item
);
  import cal_pkg::*;

  typedef struct packed {
    logic               overflow;
    logic               leap;
    logic [SUM_W-1:0]   sum;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } wsum_t;

  wsum_t             s4_item;
  logic              s4_valid;
  logic              s4_ready;
  logic [CENT_W-1:0] z_lo;
  logic [CENT_W-1:0] z_hi;
  logic [SUM_W-1:0]  sum;
  logic [4:0]        fold1;
  logic [3:0]        fold2;
  logic [2:0]        rem7;

  // January and February count as months of the previous year.
  always_comb begin
    z_lo = in_item.yr_lo;
    z_hi = in_item.yr_hi;
    if (in_item.month < MONTH_MAR) begin
      if (in_item.yr_lo == '0) begin
        z_lo = CENT_LAST;
        z_hi = in_item.yr_hi - 1'b1;
      end else begin
        z_lo = in_item.yr_lo - 1'b1;
      end
    end
  end

  // Zeller sum, with the shift to ISO numbering folded in as +5.
  assign sum = SUM_W'(in_item.day) + SUM_W'(month_term(in_item.month)) + SUM_W'(z_lo)
             + SUM_W'(z_lo >> 2) + SUM_W'(z_hi >> 2) + SUM_W'(z_hi) * SUM_W'(5)
             + SUM_W'(5);

  assign s4_ready = !out_valid || out_ready;
  assign in_ready = !s4_valid || s4_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (in_ready) begin
      s4_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s4_item.day      <= in_item.day;
      s4_item.month    <= in_item.month;
      s4_item.year     <= in_item.year;
      s4_item.sum      <= sum;
      s4_item.leap     <= is_leap(in_item.yr_lo, in_item.yr_hi);
      s4_item.overflow <= in_item.overflow;
    end
  end

  // Sum mod 7: octal digits fold since 8 is 1 mod 7.
  assign fold1 = 5'(s4_item.sum[2:0]) + 5'(s4_item.sum[5:3]) + 5'(s4_item.sum[8:6])
               + 5'(s4_item.sum[9]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
  assign rem7  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_ready) begin
      out_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid && s4_ready) begin
      out_item.day      <= s4_item.day;
      out_item.month    <= s4_item.month;
      out_item.year     <= s4_item.year;
      out_item.weekday  <= rem7 + 1'b1;
      out_item.leap     <= s4_item.leap;
      out_item.overflow <= s4_item.overflow;
    end
  end

endmodule

`default_nettype wire

[design/calendar_day_counter.sv]
// A word passes the input, century, date, weekday sum and output registers in
// turn. Throughput: one word per cycle while m_axis_tready is high; the date
// register loops on its next-day logic; the rest are plain pipeline registers.
// Reset (synchronous, active high): the date becomes 1 January 2000 and all
// pipeline stages are emptied.
`default_nettype none

module calendar_day_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // load_day, load_month, load_year, zero pad
  input  logic        s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // day_out, month_out, year_out, weekday,
                                      // leap_year, year_overflow, zero pad
);
  import cal_pkg::*;

  item_t  in_item;
  split_t split_item;
  logic   split_valid;
  logic   split_ready;
  date_t  date_item;
  logic   date_valid;
  logic   date_ready;
  res_t   res_item;

  // Unpack the input word.
  assign in_item.op    = s_axis_tuser;
  assign in_item.day   = s_axis_tdata[4:0];
  assign in_item.month = s_axis_tdata[8:5];
  assign in_item.year  = s_axis_tdata[22:9];

  // Clamp and split the year into century and year within century.
  cal_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_item  (split_item)
  );

  // Date register and next-day logic.
  cal_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_item   (split_item),
    .out_valid (date_valid),
    .out_ready (date_ready),
    .out_item  (date_item)
  );

  // Weekday and leap flag, output register.
  cal_weekday u_weekday (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (date_valid),
    .in_ready  (date_ready),
    .in_item   (date_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (res_item)
  );

  assign m_axis_tdata = {4'b0000, res_item};

`ifndef ASSERT_OFF
  // The split year always matches the full year.
  a_year_split : assert property (@(posedge clk) disable iff (rst)
    date_item.year == (YEAR_W'(date_item.yr_hi) * YEAR_CENT + YEAR_W'(date_item.yr_lo)))
    else $error("stored year and century split disagree");

  // The stored month never leaves 1 to 12.
  a_month_range : assert property (@(posedge clk) disable iff (rst)
    date_item.month != '0 && date_item.month <= MONTH_DEC)
    else $error("stored month out of range");

  // A refused advance only happens on the last day of year 9999.
  a_overflow_date : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res_item.overflow) |->
      (res_item.day == 5'd31 && res_item.month == MONTH_DEC && res_item.year == YEAR_MAX))
    else $error("overflow flagged away from 31 December 9999");

  // The weekday code is never zero.
  a_weekday_nonzero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res_item.weekday != '0)
    else $error("weekday code zero");
`endif

endmodule

`default_nettype wire

[verif/calendar_day_checker.sv]
`timescale 1ns / 1ps

// Watches both streams of the day counter. It keeps its own copy of the date,
// works out the expected result word for every accepted input word and checks
// each accepted result word against the oldest expected one.
module calendar_day_checker
  import cal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // load_day, load_month, load_year, zero pad
  input  logic        s_axis_tuser,   // operation
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // day_out, month_out, year_out, weekday,
                                      // leap_year, year_overflow, zero pad
  output int          mismatches,
  output int          outstanding,
  output int          checked,
  output int          refusals
);

  // Date as the block should hold it.
  logic [DAY_W-1:0]   cal_day;
  logic [MONTH_W-1:0] cal_month;
  logic [YEAR_W-1:0]  cal_year;

  // Result words still owed by the block, oldest first.
  res_t owed_dates[$];

  function automatic logic gregorian_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    int unsigned n;
    case (m)
      4, 6, 9, 11: n = 30;
      MONTH_FEB:   n = gregorian_leap(y) ? 29 : 28;
      default:     n = 31;
    endcase
    return n;
  endfunction

  // Zeller's congruence with January and February counted as months 13 and 14
  // of the year before, then shifted so that Monday is 1 and Sunday is 7.
  function automatic logic [WDAY_W-1:0] iso_weekday_of(input int unsigned d,
                                                      input int unsigned m,
                                                      input int unsigned y);
    int unsigned mm;
    int unsigned yy;
    int unsigned yr_in_cent;
    int unsigned cent;
    int unsigned h;
    mm = m;
    yy = y;
    if (mm < 3) begin
      mm = mm + 12;
      yy = (yy == 0) ? 0 : yy - 1;
    end
    yr_in_cent = yy % 100;
    cent = yy / 100;
    h = (d + (13 * (mm + 1)) / 5 + yr_in_cent + yr_in_cent / 4 + cent / 4 + 5 * cent) % 7;
    return WDAY_W'(((h + 5) % 7) + 1);
  endfunction

  // Applies one input word to the held date and returns the result it causes.
  function automatic res_t next_calendar_word(input logic op,
                                              input logic [DAY_W-1:0] d,
                                              input logic [MONTH_W-1:0] m,
                                              input logic [YEAR_W-1:0] y);
    res_t r;
    logic refused;
    refused = 1'b0;
    if (op == OP_LOAD) begin
      // Out-of-range fields are clamped into the calendar.
      cal_day   = (d == '0) ? DAY_FIRST : d;
      cal_month = (m == '0) ? MONTH_JAN : ((m > MONTH_DEC) ? MONTH_DEC : m);
      cal_year  = (y == '0) ? YEAR_FIRST : ((y > YEAR_MAX) ? YEAR_MAX : y);
    end else if (cal_day >= days_in(cal_month, cal_year)) begin
      // A day at or past the month's end rolls over, unless the year is exhausted.
      if (cal_month >= MONTH_DEC) begin
        if (cal_year >= YEAR_MAX) begin
          refused = 1'b1;
        end else begin
          cal_day   = DAY_FIRST;
          cal_month = MONTH_JAN;
          cal_year  = cal_year + 1'b1;
        end
      end else begin
        cal_day   = DAY_FIRST;
        cal_month = cal_month + 1'b1;
      end
    end else begin
      cal_day = cal_day + 1'b1;
    end
    r.day      = cal_day;
    r.month    = cal_month;
    r.year     = cal_year;
    r.weekday  = iso_weekday_of(cal_day, cal_month, cal_year);
    r.leap     = gregorian_leap(cal_year);
    r.overflow = refused;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t seen;
    res_t want;
    logic bad;
    if (rst) begin
      cal_day   = DAY_FIRST;
      cal_month = MONTH_JAN;
      cal_year  = YEAR_RESET;
      owed_dates.delete();
      mismatches  <= 0;
      outstanding <= 0;
      checked     <= 0;
      refusals    <= 0;
    end else begin
      // Result side is checked first; an input taken at this edge cannot
      // have produced a word yet.
      if (m_axis_tvalid && m_axis_tready) begin
        seen = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
        checked <= checked + 1;
        if (owed_dates.size() == 0) begin
          if (mismatches < 10) begin
            $display("[%0t] unexpected result word %h", $realtime, m_axis_tdata);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = owed_dates.pop_front();
          if (want.overflow) begin
            refusals <= refusals + 1;
          end
          bad = (seen.day != want.day) || (seen.month != want.month) ||
                (seen.year != want.year) || (seen.weekday != want.weekday) ||
                (seen.leap != want.leap) || (seen.overflow != want.overflow);
          if (bad) begin
            if (mismatches < 10) begin
              $display("[%0t] mismatch: expected %0d.%0d.%0d wd %0d leap %0d ovf %0d",
                       $realtime, want.day, want.month, want.year, want.weekday,
                       want.leap, want.overflow);
              $display("[%0t]           actual   %0d.%0d.%0d wd %0d leap %0d ovf %0d",
                       $realtime, seen.day, seen.month, seen.year, seen.weekday,
                       seen.leap, seen.overflow);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      // Input side: advance the held date and record what must come out.
      if (s_axis_tvalid && s_axis_tready) begin
        owed_dates.insert(owed_dates.size(),
                          next_calendar_word(s_axis_tuser, s_axis_tdata[4:0],
                                             s_axis_tdata[8:5], s_axis_tdata[22:9]));
      end
      outstanding <= owed_dates.size();
    end
  end

endmodule

[verif/tb_calendar_day_counter.sv]
`timescale 1ns / 1ps

// Drives loads and day advances into the day counter under four pacing mixes
// and leaves all checking to the checker beside the block.
module tb_calendar_day_counter;
  import cal_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // load_day, load_month, load_year, zero pad
  logic        s_axis_tuser = OP_LOAD;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // day_out, month_out, year_out, weekday,
                               // leap_year, year_overflow, zero pad

  int mismatches;
  int outstanding;
  int checked;
  int refusals;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          words_sent = 0;
  int          loads_sent = 0;
  int unsigned cycle_count = 0;

  calendar_day_counter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  calendar_day_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .checked       (checked),
    .refusals      (refusals)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results owed", cycle_count, outstanding);
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one word, with random idle cycles first, and returns once it is taken.
  task automatic send_word(input logic op, input logic [DAY_W-1:0] d,
                           input logic [MONTH_W-1:0] m, input logic [YEAR_W-1:0] y);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, y, m, d};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    words_sent++;
    if (op == OP_LOAD) begin
      loads_sent++;
    end
  endtask

  // The date fields of an advance are ignored, so they carry noise.
  task automatic send_advance();
    send_word(OP_ADVANCE, DAY_W'($urandom_range(31)), MONTH_W'($urandom_range(15)),
              YEAR_W'($urandom_range(16383)));
  endtask

  // Stops sending and waits until every owed result word has come out.
  task automatic wait_until_settled();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly a load near a month, year or century boundary followed by a run
  // of advances; the rest are loads with unconstrained fields and a short run.
  task automatic run_random(input int quota);
    int first;
    int run_len;
    int yr;
    int mo;
    int dy;
    first = words_sent;
    while (words_sent - first < quota) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(4))
          0:       yr = $urandom_range(1, 99) * 100 - 1 + $urandom_range(2);
          1:       yr = 9999 - $urandom_range(2);
          2:       yr = $urandom_range(1, 4);
          3:       yr = $urandom_range(1, 2499) * 4;
          default: yr = $urandom_range(1, 9999);
        endcase
        case ($urandom_range(9))
          0, 1, 2: mo = 12;
          3:       mo = 2;
          default: mo = $urandom_range(1, 12);
        endcase
        dy = ($urandom_range(1) == 0) ? $urandom_range(24, 31) : $urandom_range(1, 31);
        send_word(OP_LOAD, DAY_W'(dy), MONTH_W'(mo), YEAR_W'(yr));
        run_len = $urandom_range(1, 40);
      end else begin
        send_word(OP_LOAD, DAY_W'($urandom_range(31)), MONTH_W'($urandom_range(15)),
                  YEAR_W'($urandom_range(16383)));
        run_len = $urandom_range(0, 3);
      end
      repeat (run_len) send_advance();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: the reset date, leap rules, month and year rollover, clamping
    // of out-of-range loads, a day past the month's length, and overflow.
    send_advance();
    send_word(OP_LOAD, 5'd28, 4'd2, 14'd2000);
    send_advance();
    send_advance();
    send_word(OP_LOAD, 5'd28, 4'd2, 14'd1900);
    send_advance();
    send_word(OP_LOAD, 5'd28, 4'd2, 14'd2024);
    send_advance();
    send_word(OP_LOAD, 5'd31, 4'd12, 14'd1999);
    send_advance();
    send_word(OP_LOAD, 5'd30, 4'd11, 14'd2023);
    send_advance();
    send_word(OP_LOAD, 5'd31, 4'd2, 14'd2023);
    send_advance();
    send_word(OP_LOAD, 5'd0, 4'd0, 14'd0);
    send_advance();
    send_word(OP_LOAD, 5'd31, 4'd15, 14'd16383);
    send_advance();
    send_advance();
    send_word(OP_LOAD, 5'd5, 4'd13, 14'd10000);
    send_word(OP_LOAD, 5'd31, 4'd4, 14'd9999);
    send_advance();
    send_word(OP_LOAD, 5'd31, 4'd12, 14'd9998);
    send_advance();

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    run_random(385);
    wait_until_settled();
    idle_pct = 45;
    run_random(410);
    wait_until_settled();
    idle_pct = 0;
    stall_pct <= 45;
    run_random(410);
    wait_until_settled();
    idle_pct = 11;
    stall_pct <= 11;
    run_random(410);
    wait_until_settled();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d date words (%0d loads, %0d advances) under four pacing mixes;",
             words_sent, loads_sent, words_sent - loads_sent);
    $display("%0d result words compared, %0d refused advances past the last year.",
             checked, refusals);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[calendar_day_counter.f]
design/cal_pkg.sv
design/cal_split.sv
design/cal_date.sv
design/cal_weekday.sv
design/calendar_day_counter.sv
verif/calendar_day_checker.sv
verif/tb_calendar_day_counter.sv
